/* rtl/ksw_pkg.sv */
// shared constants, types and helpers of the key-switch block
`default_nettype none

package ksw_pkg;

    // default sizing of the stores
    localparam int MAX_ROWS_DEF     = 16;
    localparam int MAX_ELEMENTS_DEF = 16;
    localparam int MAX_DIGITS_DEF   = 60;

    // fixed field widths
    localparam int WORD_W    = 64;
    localparam int ROW_IDX_W = 6;
    localparam int COL_IDX_W = 12;
    localparam int CFG_W     = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // register reset values
    localparam logic [CFG_W-1:0] ROWS_RST   = 7'd16;
    localparam logic [CFG_W-1:0] DIGITS_RST = 7'd60;

    // operation codes of an input word
    localparam logic OP_MATRIX_WRITE = 1'b0;
    localparam logic OP_ELEMENT      = 1'b1;

    // register indexes (byte address bit 2)
    localparam logic REG_ROWS   = 1'b0;
    localparam logic REG_DIGITS = 1'b1;

    // register values already saturated to their usable range
    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] digits;
    } ksw_cfg_t;

    // saturate a register value to 1..hi
    function automatic logic [CFG_W-1:0] clamp_range(input logic [CFG_W-1:0] v,
                                                     input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] res;
        begin
            res = v;
            if (v == '0)
            begin
                res = 7'd1;
            end
            else if (v > hi)
            begin
                res = hi;
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/ksw_in_if.sv */
// input channel: matrix words and cipher elements
`default_nettype none

interface ksw_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic [ksw_pkg::ROW_IDX_W-1:0]         row_index;
    logic [ksw_pkg::COL_IDX_W-1:0]         column_index;
    logic signed [ksw_pkg::WORD_W-1:0]     value;
    logic                                  last;

    modport source (output valid, output operation, output row_index,
                    output column_index, output value, output last, input ready);
    modport sink   (input valid, input operation, input row_index,
                    input column_index, input value, input last, output ready);
endinterface

`default_nettype wire

/* rtl/ksw_out_if.sv */
// output channel: switched cipher elements
`default_nettype none

interface ksw_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [ksw_pkg::ROW_IDX_W-1:0]         out_row;
    logic signed [ksw_pkg::WORD_W-1:0]     out_value;
    logic                                  out_last;

    modport source (output valid, output out_row, output out_value,
                    output out_last, input ready);
    modport sink   (input valid, input out_row, input out_value,
                    input out_last, output ready);
endinterface

`default_nettype wire

/* rtl/ksw_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module ksw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/ksw_engine.sv */
// matrix store, accumulator store and the digit/row sequencer
`default_nettype none

module ksw_engine #(
    parameter int MAX_ROWS     = ksw_pkg::MAX_ROWS_DEF,
    parameter int MAX_ELEMENTS = ksw_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_DIGITS   = ksw_pkg::MAX_DIGITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ksw_pkg::ksw_cfg_t cfg,
    ksw_in_if.sink                 items,
    ksw_out_if.source              results
);

    localparam int STORE_COLS  = MAX_ELEMENTS * MAX_DIGITS;
    localparam int STORE_WORDS = MAX_ROWS * STORE_COLS;
    localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int CW = (STORE_COLS > 1) ? $clog2(STORE_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int EW = $clog2(MAX_ELEMENTS + 1);
    localparam int WW = ksw_pkg::WORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIG,
        S_ACC,
        S_FIN,
        S_ORD,
        S_OLD
    } state_t;

    state_t                state_reg, state_next;
    logic [DW-1:0]         j_reg, j_next;
    logic [RW-1:0]         r_reg, r_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [AW-1:0]         row_off_reg, row_off_next;
    logic [MAX_DIGITS-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic                  last_reg, last_next;
    logic [EW-1:0]         count_reg, count_next;
    logic [MAX_ROWS-1:0]   acc_valid_reg, acc_valid_next;
    logic                  p1_valid_reg, p1_valid_next;
    logic [RW-1:0]         p1_row_reg, p1_row_next;
    logic                  fwd_hit_reg, fwd_hit_next;
    logic [WW-1:0]         fwd_data_reg, fwd_data_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [RW-1:0]         out_row_reg, out_row_next;
    logic [WW-1:0]         out_value_reg, out_value_next;
    logic                  out_last_reg, out_last_next;

    // memory ports
    logic          mat_we;
    logic [AW-1:0] mat_waddr;
    logic [AW-1:0] mat_raddr;
    logic [WW-1:0] mat_rdata;
    logic          acc_we;
    logic [RW-1:0] acc_waddr;
    logic [WW-1:0] acc_wdata;
    logic [RW-1:0] acc_raddr;
    logic [WW-1:0] acc_rdata;
    logic          acc_rd_issue;

    logic          in_accept;
    logic          wr_in_range;
    logic [WW-1:0] in_mag;
    logic [WW-1:0] acc_old;
    logic [DW-1:0] digits_m1;
    logic [RW-1:0] rows_m1;

    ksw_ram #(
        .WIDTH (WW),
        .DEPTH (STORE_WORDS)
    ) u_matrix_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (items.value),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    ksw_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_ROWS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    assign digits_m1 = DW'(cfg.digits - 7'd1);
    assign rows_m1   = RW'(cfg.rows - 7'd1);

    assign items.ready = (state_reg == S_IDLE);
    assign in_accept   = items.valid && items.ready;

    // matrix word write straight from the input word
    assign wr_in_range = (32'(items.row_index) < MAX_ROWS) &&
                         (32'(items.column_index) < STORE_COLS);
    assign mat_we      = in_accept && (items.operation == ksw_pkg::OP_MATRIX_WRITE) &&
                         wr_in_range;
    assign mat_waddr   = AW'(32'(items.row_index) * STORE_COLS + 32'(items.column_index));
    assign mat_raddr   = row_off_reg + AW'(col_reg);

    assign in_mag = items.value[WW-1] ? (WW'(0) - WW'(items.value)) : WW'(items.value);

    // accumulator value of the read issued last cycle, with forwarding
    assign acc_old = fwd_hit_reg ? fwd_data_reg : (rd_valid_reg ? acc_rdata : '0);

    // second stage of the read-modify-write
    assign acc_we    = p1_valid_reg;
    assign acc_waddr = p1_row_reg;
    assign acc_wdata = neg_reg ? (acc_old - mat_rdata) : (acc_old + mat_rdata);

    assign acc_raddr    = r_reg;
    assign acc_rd_issue = (state_reg == S_ACC) ||
                          ((state_reg == S_ORD) && (!out_valid_reg || results.ready));

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        r_next         = r_reg;
        col_next       = col_reg;
        row_off_next   = row_off_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        acc_valid_next = acc_valid_reg;
        p1_valid_next  = 1'b0;
        p1_row_next    = p1_row_reg;
        fwd_hit_next   = acc_rd_issue && acc_we && (acc_raddr == acc_waddr);
        fwd_data_next  = acc_wdata;
        rd_valid_next  = acc_valid_reg[acc_raddr];
        out_valid_next = out_valid_reg && !results.ready;
        out_row_next   = out_row_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        if (acc_we)
        begin
            acc_valid_next[acc_waddr] = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (items.operation == ksw_pkg::OP_ELEMENT))
                begin
                    neg_next  = items.value[WW-1];
                    mag_next  = in_mag[MAX_DIGITS-1:0];
                    last_next = items.last;
                    j_next    = '0;
                    col_next  = CW'(32'(count_reg) * 32'(cfg.digits));
                    if (32'(count_reg) < MAX_ELEMENTS)
                    begin
                        count_next = count_reg + EW'(1);
                        state_next = S_DIG;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_DIG:
            begin
                if (mag_reg[j_reg])
                begin
                    r_next       = '0;
                    row_off_next = '0;
                    state_next   = S_ACC;
                end
                else if (j_reg == digits_m1)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    j_next   = j_reg + DW'(1);
                    col_next = col_reg + CW'(1);
                end
            end
            S_ACC:
            begin
                // one matrix word and one accumulator read per row
                p1_valid_next = 1'b1;
                p1_row_next   = r_reg;
                if (r_reg == RW'(MAX_ROWS - 1))
                begin
                    if (j_reg == digits_m1)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        j_next     = j_reg + DW'(1);
                        col_next   = col_reg + CW'(1);
                        state_next = S_DIG;
                    end
                end
                else
                begin
                    r_next       = r_reg + RW'(1);
                    row_off_next = row_off_reg + AW'(STORE_COLS);
                end
            end
            S_FIN:
            begin
                r_next = '0;
                if (last_reg)
                begin
                    state_next = S_ORD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ORD:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = S_OLD;
                end
            end
            S_OLD:
            begin
                out_valid_next = 1'b1;
                out_row_next   = r_reg;
                out_value_next = acc_old;
                out_last_next  = (r_reg == rows_m1);
                if (r_reg == rows_m1)
                begin
                    acc_valid_next = '0;
                    count_next     = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = S_ORD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            j_reg         <= '0;
            r_reg         <= '0;
            col_reg       <= '0;
            row_off_reg   <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            acc_valid_reg <= '0;
            p1_valid_reg  <= 1'b0;
            p1_row_reg    <= '0;
            fwd_hit_reg   <= 1'b0;
            fwd_data_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            r_reg         <= r_next;
            col_reg       <= col_next;
            row_off_reg   <= row_off_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            acc_valid_reg <= acc_valid_next;
            p1_valid_reg  <= p1_valid_next;
            p1_row_reg    <= p1_row_next;
            fwd_hit_reg   <= fwd_hit_next;
            fwd_data_reg  <= fwd_data_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            out_row_reg   <= out_row_next;
            out_value_reg <= out_value_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.out_row   = ksw_pkg::ROW_IDX_W'(out_row_reg);
    assign results.out_value = out_value_reg;
    assign results.out_last  = out_last_reg;

    // accumulator update only follows a row read
    a_update_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> $past(state_reg == S_ACC))
        else $error("accumulator update without a preceding row read");

    // a result never overwrites a word still waiting on the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OLD) |-> $past(!out_valid_reg || results.ready))
        else $error("output word overwritten before it was taken");

    // the vector state is cleared once the last row has been read out
    a_cleared_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && $past(state_reg == S_OLD)) |->
        ((acc_valid_reg == '0) && (count_reg == '0)))
        else $error("accumulators not cleared after the result vector");

    // forwarding only when an update was in flight
    a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> $past(p1_valid_reg))
        else $error("forwarded accumulator without an update");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_ELEMENTS)
        else $error("element count beyond the matrix width");

endmodule

`default_nettype wire

/* rtl/vector_he_key_switch_core.sv */
// top level of the key-switch block: register port and engine
`default_nettype none

//  channel  | direction | word                                        | handshake
//  ---------+-----------+---------------------------------------------+-------------
//  items    | in        | operation, row_index, column_index, value,  | valid/ready
//           |           | last                                        |
//  results  | out       | out_row, out_value, out_last                | valid/ready
//  apb      | in        | rows_in_use @ 0x0, digits_in_use @ 0x4       | psel/penable
//
//  a matrix word write is stored straight from the input word; an element walks
//  its digits and, for each set magnitude bit, reads all MAX_ROWS rows through the
//  single read port of the matrix ram, one word per row and digit
//  each result row is an accumulator read, then an output load, plus stalls
//  reset clears registers and accumulator valid bits at once; no clearing pass
//  a stalled output holds the last row in the output register; new items are
//  taken while the final row of a vector still waits

module vector_he_key_switch_core #(
    parameter int MAX_ROWS     = ksw_pkg::MAX_ROWS_DEF,
    parameter int MAX_ELEMENTS = ksw_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_DIGITS   = ksw_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ksw_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [ksw_pkg::PDATA_W-1:0]    pwdata,
    output logic      [ksw_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready,
    // data channels
    ksw_in_if.sink                              items,
    ksw_out_if.source                           results
);

    logic [ksw_pkg::CFG_W-1:0] rows_reg, rows_next;
    logic [ksw_pkg::CFG_W-1:0] digits_reg, digits_next;
    logic                      cfg_write;
    logic                      reg_sel;
    ksw_pkg::ksw_cfg_t         cfg;

    // no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    // register index is byte address bit 2
    assign reg_sel   = paddr[2];

    always_comb
    begin
        rows_next   = rows_reg;
        digits_next = digits_reg;
        if (cfg_write)
        begin
            case (reg_sel)
                ksw_pkg::REG_ROWS:   rows_next   = pwdata[ksw_pkg::CFG_W-1:0];
                ksw_pkg::REG_DIGITS: digits_next = pwdata[ksw_pkg::CFG_W-1:0];
                default:             rows_next   = rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= ksw_pkg::ROWS_RST;
            digits_reg <= ksw_pkg::DIGITS_RST;
        end
        else
        begin
            rows_reg   <= rows_next;
            digits_reg <= digits_next;
        end
    end

    // read back the raw register contents
    always_comb
    begin
        case (reg_sel)
            ksw_pkg::REG_ROWS:   prdata = ksw_pkg::PDATA_W'(rows_reg);
            ksw_pkg::REG_DIGITS: prdata = ksw_pkg::PDATA_W'(digits_reg);
            default:             prdata = '0;
        endcase
    end

    // out-of-range settings are used saturated to the store geometry
    assign cfg.rows   = ksw_pkg::clamp_range(rows_reg, ksw_pkg::CFG_W'(MAX_ROWS));
    assign cfg.digits = ksw_pkg::clamp_range(digits_reg, ksw_pkg::CFG_W'(MAX_DIGITS));

    ksw_engine #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_DIGITS   (MAX_DIGITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .items   (items),
        .results (results)
    );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// self-checking testbench of the key-switch core: matrix load, directed table, random vectors
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ksw_pkg::*;

    // sizing follows the default build of the core
    localparam int N_ROWS     = MAX_ROWS_DEF;
    localparam int N_ELEMS    = MAX_ELEMENTS_DEF;
    localparam int N_DIGITS   = MAX_DIGITS_DEF;
    localparam int STORE_COLS = N_ELEMS * N_DIGITS;

    // worst element: every digit set, one matrix read per row and digit, plus margin
    localparam int SETTLE_CYCLES   = 2 * (4 + N_DIGITS * (N_ROWS + 1));
    localparam int RESET_CYCLES    = 8;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 37;

    // one word of the item channel
    typedef struct packed {
        logic                 operation;
        logic [ROW_IDX_W-1:0] row_index;
        logic [COL_IDX_W-1:0] column_index;
        logic [WORD_W-1:0]    value;
        logic                 last;
    } ksw_word_t;

    // one switched row as the result channel should carry it
    typedef struct {
        logic [ROW_IDX_W-1:0] out_row;
        logic [WORD_W-1:0]    out_value;
        logic                 out_last;
    } switched_row_t;

    // directed table: either a register write or a word sent reps times
    typedef enum logic {ROW_ITEM, ROW_CFG} dir_kind_t;

    typedef struct packed {
        dir_kind_t        kind;
        logic             reg_sel;
        logic [CFG_W-1:0] reg_value;
        ksw_word_t        word;
        logic [7:0]       reps;
        logic             typed;      // expected rows typed in below, not predicted
        logic [CFG_W-1:0] exp_rows;
        logic [WORD_W-1:0] exp_value;
    } dir_row_t;

    localparam int N_DIR = 19;

    localparam dir_row_t DIR_TAB [N_DIR] = '{
        // zero element after the matrix load: every default row reads back zero
        '{ROW_ITEM, REG_ROWS, 7'd0, '{OP_ELEMENT, 6'd0, 12'd0, 64'd0, 1'b1},
          8'd1, 1'b1, 7'd16, 64'd0},
        // row beyond the store: write ignored
        '{ROW_ITEM, REG_ROWS, 7'd0,
          '{OP_MATRIX_WRITE, 6'd63, 12'd0, 64'h0123_4567_89ab_cdef, 1'b0},
          8'd1, 1'b0, 7'd0, 64'd0},
        // column beyond the store: write ignored, its last mark too
        '{ROW_ITEM, REG_ROWS, 7'd0,
          '{OP_MATRIX_WRITE, 6'd0, 12'd4095, 64'hfedc_ba98_7654_3210, 1'b1},
          8'd1, 1'b0, 7'd0, 64'd0},
        // top corner of the store, last mark on a write yields nothing
        '{ROW_ITEM, REG_ROWS, 7'd0,
          '{OP_MATRIX_WRITE, 6'd15, 12'd959, 64'hffff_ffff_ffff_ffff, 1'b1},
          8'd1, 1'b0, 7'd0, 64'd0},
        // largest positive element
        '{ROW_ITEM, REG_ROWS, 7'd0,
          '{OP_ELEMENT, 6'd63, 12'd4095, 64'h7fff_ffff_ffff_ffff, 1'b0},
          8'd1, 1'b0, 7'd0, 64'd0},
        // most negative element: only digit 63, beyond 60 digits
        '{ROW_ITEM, REG_ROWS, 7'd0,
          '{OP_ELEMENT, 6'd0, 12'd0, 64'h8000_0000_0000_0000, 1'b0},
          8'd1, 1'b0, 7'd0, 64'd0},
        // fill the vector to its element limit, reaching column 959
        '{ROW_ITEM, REG_ROWS, 7'd0,
          '{OP_ELEMENT, 6'd21, 12'd1234, 64'h0800_0000_0000_0000, 1'b0},
          8'd14, 1'b0, 7'd0, 64'd0},
        // element past the limit adds nothing but still flushes
        '{ROW_ITEM, REG_ROWS, 7'd0,
          '{OP_ELEMENT, 6'd42, 12'd2345, 64'hffff_ffff_ffff_ffff, 1'b1},
          8'd1, 1'b0, 7'd0, 64'd0},
        // zero registers saturate to one row and one digit
        '{ROW_CFG, REG_ROWS, 7'd0, '{OP_ELEMENT, 6'd0, 12'd0, 64'd0, 1'b0},
          8'd0, 1'b0, 7'd0, 64'd0},
        '{ROW_CFG, REG_DIGITS, 7'd0, '{OP_ELEMENT, 6'd0, 12'd0, 64'd0, 1'b0},
          8'd0, 1'b0, 7'd0, 64'd0},
        '{ROW_ITEM, REG_ROWS, 7'd0, '{OP_ELEMENT, 6'd0, 12'd0, 64'd0, 1'b1},
          8'd1, 1'b1, 7'd1, 64'd0},
        // most negative with a single digit: no digit set, sum stays zero
        '{ROW_ITEM, REG_ROWS, 7'd0,
          '{OP_ELEMENT, 6'd0, 12'd0, 64'h8000_0000_0000_0000, 1'b1},
          8'd1, 1'b1, 7'd1, 64'd0},
        '{ROW_ITEM, REG_ROWS, 7'd0,
          '{OP_ELEMENT, 6'd0, 12'd0, 64'hffff_ffff_ffff_ffff, 1'b1},
          8'd1, 1'b0, 7'd0, 64'd0},
        // all-ones registers saturate to the full store
        '{ROW_CFG, REG_ROWS, 7'd127, '{OP_ELEMENT, 6'd0, 12'd0, 64'd0, 1'b0},
          8'd0, 1'b0, 7'd0, 64'd0},
        '{ROW_CFG, REG_DIGITS, 7'd127, '{OP_ELEMENT, 6'd0, 12'd0, 64'd0, 1'b0},
          8'd0, 1'b0, 7'd0, 64'd0},
        '{ROW_ITEM, REG_ROWS, 7'd0,
          '{OP_ELEMENT, 6'd0, 12'd0, 64'haaaa_aaaa_aaaa_aaaa, 1'b1},
          8'd1, 1'b0, 7'd0, 64'd0},
        // value 64, above the store geometry, also saturated
        '{ROW_CFG, REG_ROWS, 7'd64, '{OP_ELEMENT, 6'd0, 12'd0, 64'd0, 1'b0},
          8'd0, 1'b0, 7'd0, 64'd0},
        '{ROW_CFG, REG_DIGITS, 7'd64, '{OP_ELEMENT, 6'd0, 12'd0, 64'd0, 1'b0},
          8'd0, 1'b0, 7'd0, 64'd0},
        '{ROW_ITEM, REG_ROWS, 7'd0,
          '{OP_ELEMENT, 6'd0, 12'd0, 64'h5555_5555_5555_5555, 1'b1},
          8'd1, 1'b0, 7'd0, 64'd0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    ksw_in_if  items_ch();
    ksw_out_if results_ch();

    vector_he_key_switch_core #(
        .MAX_ROWS     (N_ROWS),
        .MAX_ELEMENTS (N_ELEMS),
        .MAX_DIGITS   (N_DIGITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .items   (items_ch),
        .results (results_ch)
    );

    // predictor state: own copy of store, accumulators and registers
    logic [WORD_W-1:0] key_mat [N_ROWS][STORE_COLS];
    logic [WORD_W-1:0] row_sum [N_ROWS];
    int unsigned       elems_taken = 0;
    logic [CFG_W-1:0]  rows_cfg    = ROWS_RST;
    logic [CFG_W-1:0]  digits_cfg  = DIGITS_RST;

    // switched rows still to come, oldest first
    switched_row_t switched_q [$];

    int  mismatch_cnt = 0;
    int  rows_checked = 0;
    int  words_sent   = 0;
    int  cfg_writes   = 0;
    bit  words_held   = 1'b1;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on a hung handshake or a missing result
    initial
    begin
        #60ms;
        $display("vector_he_key_switch_core verification failed");
        $finish;
    end

    // saturate a register value to 1..hi
    function automatic int unsigned fit_range(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v == '0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // append one expected row at the tail
    function automatic void expect_row(input switched_row_t sr);
        switched_q = {switched_q, sr};
    endfunction

    // apply one accepted word to the predictor; keep selects whether its rows are queued
    function automatic void predict_switch(input ksw_word_t w, input bit keep);
        logic              neg;
        logic [WORD_W-1:0] mag;
        int unsigned       n_dig;
        int unsigned       n_out;
        int unsigned       base;
        switched_row_t     sr;
        if (w.operation == OP_MATRIX_WRITE)
        begin
            // out-of-range writes fall away, last is ignored
            if (w.row_index < N_ROWS && w.column_index < STORE_COLS)
                key_mat[w.row_index][w.column_index] = w.value;
            return;
        end
        neg   = w.value[WORD_W-1];
        mag   = neg ? (~w.value + 1'b1) : w.value;
        n_dig = fit_range(digits_cfg, N_DIGITS);
        // elements past the limit only count for their last mark
        if (elems_taken < N_ELEMS)
        begin
            base = elems_taken * n_dig;
            for (int j = 0; j < n_dig; j++)
            begin
                if (mag[j])
                begin
                    for (int r = 0; r < N_ROWS; r++)
                        row_sum[r] = neg ? row_sum[r] - key_mat[r][base + j]
                                         : row_sum[r] + key_mat[r][base + j];
                end
            end
            elems_taken++;
        end
        if (!w.last)
            return;
        n_out = fit_range(rows_cfg, N_ROWS);
        for (int r = 0; r < n_out; r++)
        begin
            sr.out_row   = ROW_IDX_W'(r);
            sr.out_value = row_sum[r];
            sr.out_last  = (r + 1 == n_out);
            if (keep)
                expect_row(sr);
        end
        // every accumulator clears, emitted or not
        for (int r = 0; r < N_ROWS; r++)
            row_sum[r] = '0;
        elems_taken = 0;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // matrix word write, mostly inside the store, some outside
    function automatic ksw_word_t random_matrix_word();
        ksw_word_t w;
        int        roll;
        roll           = $urandom_range(0, 9);
        w.operation    = OP_MATRIX_WRITE;
        w.row_index    = ROW_IDX_W'($urandom_range(0, N_ROWS - 1));
        w.column_index = COL_IDX_W'($urandom_range(0, STORE_COLS - 1));
        w.value        = rand_word();
        w.last         = 1'($urandom_range(0, 1));
        if (roll == 0)
            w.row_index = ROW_IDX_W'($urandom_range(N_ROWS, 63));
        else if (roll == 1)
            w.column_index = COL_IDX_W'($urandom_range(STORE_COLS, 4095));
        return w;
    endfunction

    // cipher element with a mix of extreme, sparse, short and full magnitudes
    function automatic ksw_word_t random_element(input logic is_last);
        ksw_word_t         w;
        logic [WORD_W-1:0] v;
        int                roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:
            begin
                case ($urandom_range(0, 4))
                    0: v = '0;
                    1: v = 64'h7fff_ffff_ffff_ffff;
                    2: v = 64'h8000_0000_0000_0000;
                    3: v = '1;
                    default: v = 64'd1;
                endcase
            end
            1, 2:
            begin
                v = 64'd1 << $urandom_range(0, 63);
                if ($urandom_range(0, 1))
                    v = ~v + 1'b1;
            end
            3, 4, 5:
            begin
                // shift by 64 leaves the mask all ones
                v = rand_word() & ((64'd1 << $urandom_range(1, 64)) - 64'd1);
                if ($urandom_range(0, 1))
                    v = ~v + 1'b1;
            end
            default:
                v = rand_word();
        endcase
        w.operation    = OP_ELEMENT;
        w.row_index    = ROW_IDX_W'($urandom_range(0, 63));
        w.column_index = COL_IDX_W'($urandom_range(0, 4095));
        w.value        = v;
        w.last         = is_last;
        return w;
    endfunction

    // offer one word after a random gap, predict it once taken
    task automatic send_word(input ksw_word_t w, input bit keep);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid        <= 1'b1;
        items_ch.operation    <= w.operation;
        items_ch.row_index    <= w.row_index;
        items_ch.column_index <= w.column_index;
        items_ch.value        <= w.value;
        items_ch.last         <= w.last;
        words_held = 1'b0;
        do @(posedge clk); while (!items_ch.ready);
        predict_switch(w, keep);
        words_sent++;
    endtask

    // drop valid once, only if a word is still offered
    task automatic hold_words();
        if (!words_held)
        begin
            items_ch.valid <= 1'b0;
            words_held = 1'b1;
        end
    endtask

    task automatic wait_drained();
        while (switched_q.size() != 0)
            @(posedge clk);
    endtask

    // block idle: nothing offered, every row back, trailing element done
    task automatic settle();
        hold_words();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle, access cycle, then the bus released and left idle
    task automatic set_register(input logic sel, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_ROWS)
            rows_cfg = data[CFG_W-1:0];
        else
            digits_cfg = data[CFG_W-1:0];
        cfg_writes++;
        @(posedge clk);
    endtask

    // result side: runs of ready broken by random stalls
    initial
    begin
        int run;
        int gap;
        results_ch.ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        forever
        begin
            run = $urandom_range(1, 24);
            results_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // compare every taken row with the oldest expected one
    always @(posedge clk)
    begin : row_check
        switched_row_t exp_r;
        if (rst_n === 1'b1 && results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
        begin
            if (switched_q.size() == 0)
            begin
                $error("result row %0d with no row expected", results_ch.out_row);
                mismatch_cnt++;
            end
            else
            begin
                exp_r = switched_q.pop_front();
                rows_checked++;
                if (results_ch.out_row !== exp_r.out_row)
                begin
                    $error("out_row: expected %0d, got %0d", exp_r.out_row, results_ch.out_row);
                    mismatch_cnt++;
                end
                if (results_ch.out_value !== exp_r.out_value)
                begin
                    $error("out_value: expected %h, got %h",
                           exp_r.out_value, results_ch.out_value);
                    mismatch_cnt++;
                end
                if (results_ch.out_last !== exp_r.out_last)
                begin
                    $error("out_last: expected %0b, got %0b",
                           exp_r.out_last, results_ch.out_last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        ksw_word_t     w;
        switched_row_t sr;
        logic [CFG_W-1:0] rows_val;
        logic [CFG_W-1:0] digits_val;
        int            done_items;
        int            vlen;

        for (int r = 0; r < N_ROWS; r++)
            row_sum[r] = '0;

        // every input known from time zero
        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        items_ch.valid        <= 1'b0;
        items_ch.operation    <= OP_MATRIX_WRITE;
        items_ch.row_index    <= '0;
        items_ch.column_index <= '0;
        items_ch.value        <= '0;
        items_ch.last         <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load the whole store so no element ever reads an unwritten word
        for (int r = 0; r < N_ROWS; r++)
        begin
            for (int c = 0; c < STORE_COLS; c++)
            begin
                w.operation    = OP_MATRIX_WRITE;
                w.row_index    = ROW_IDX_W'(r);
                w.column_index = COL_IDX_W'(c);
                w.last         = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 31))
                    0: w.value = 64'h7fff_ffff_ffff_ffff;
                    1: w.value = 64'h8000_0000_0000_0000;
                    2: w.value = '1;
                    default: w.value = rand_word();
                endcase
                send_word(w, 1'b1);
            end
        end

        // directed table; register rows wait for an idle block
        for (int i = 0; i < N_DIR; i++)
        begin
            if (DIR_TAB[i].kind == ROW_CFG)
            begin
                settle();
                set_register(DIR_TAB[i].reg_sel, {{(PDATA_W-CFG_W){1'b0}}, DIR_TAB[i].reg_value});
            end
            else
            begin
                repeat (DIR_TAB[i].reps)
                    send_word(DIR_TAB[i].word, !DIR_TAB[i].typed);
                if (DIR_TAB[i].typed)
                begin
                    for (int r = 0; r < DIR_TAB[i].exp_rows; r++)
                    begin
                        sr.out_row   = ROW_IDX_W'(r);
                        sr.out_value = DIR_TAB[i].exp_value;
                        sr.out_last  = (r + 1 == DIR_TAB[i].exp_rows);
                        expect_row(sr);
                    end
                end
            end
        end

        // random vectors under several register settings
        for (int p = 0; p < N_PHASES; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    rows_val   = CFG_W'($urandom_range(1, N_ROWS));
                    digits_val = CFG_W'($urandom_range(1, N_DIGITS));
                end
                1:
                begin
                    rows_val   = CFG_W'(N_ROWS);
                    digits_val = CFG_W'(N_DIGITS);
                end
                2:
                begin
                    rows_val   = CFG_W'(1);
                    digits_val = CFG_W'(1);
                end
                3:
                begin
                    // above range: saturated by the core
                    rows_val   = CFG_W'($urandom_range(N_ROWS + 1, 127));
                    digits_val = CFG_W'($urandom_range(N_DIGITS + 1, 127));
                end
                4:
                begin
                    rows_val   = CFG_W'($urandom_range(1, N_ROWS));
                    digits_val = CFG_W'($urandom_range(1, 8));
                end
                default:
                begin
                    rows_val   = CFG_W'($urandom_range(0, 127));
                    digits_val = CFG_W'($urandom_range(0, 127));
                end
            endcase
            // upper data bits are don't-care, toggle them anyway
            set_register(REG_ROWS, ($urandom & 32'hffff_ff80) | rows_val);
            set_register(REG_DIGITS, ($urandom & 32'hffff_ff80) | digits_val);

            done_items = 0;
            while (done_items < ITEMS_PER_PHASE)
            begin
                // mostly short vectors, now and then past the element limit
                vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(N_ELEMS - 1, N_ELEMS + 4)
                                                   : $urandom_range(1, 4);
                for (int k = 0; k < vlen; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        w = random_matrix_word();
                        send_word(w, 1'b1);
                        if (w.row_index < N_ROWS && w.column_index < STORE_COLS)
                            done_items++;
                    end
                    w = random_element(k == vlen - 1);
                    send_word(w, 1'b1);
                    done_items++;
                end
                // sender backs off until the core has emptied
                if ($urandom_range(0, 7) == 0)
                begin
                    hold_words();
                    wait_drained();
                    @(posedge clk);
                end
            end
        end

        // drain, then give a trailing element time to misbehave
        hold_words();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d words incl. a %0d-word matrix load, over %0d register writes",
                 words_sent, N_ROWS * STORE_COLS, cfg_writes);
        $display("checked %0d switched rows, %0d mismatches", rows_checked, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("vector_he_key_switch_core verification clean");
        else
            $display("vector_he_key_switch_core verification failed");
        $finish;
    end

endmodule

/* vector_he_key_switch_core.f */
rtl/ksw_pkg.sv
rtl/ksw_in_if.sv
rtl/ksw_out_if.sv
rtl/ksw_ram.sv
rtl/ksw_engine.sv
rtl/vector_he_key_switch_core.sv
dv/tb_top.sv
